// ----- hw/rtl/ttac_pkg.sv -----
// Shared constants for the tile-to-atlas coordinate mapper.
// Field widths, register reset value and default geometry parameters.
// No dependencies.
package ttac_pkg;

    // Default atlas geometry
    localparam int TILE_SIZE_DEF       = 32;
    localparam int LANE_WIDTH_DEF      = 256;
    localparam int SHORT_LANES_DEF     = 3;
    localparam int RESERVED_HEIGHT_DEF = 928;

    // Field widths
    localparam int TILE_X_W = 3;
    localparam int TILE_Y_W = 11;
    localparam int HEIGHT_W = 15;
    localparam int OUT_W    = 14;

    // Register reset value and output ceiling
    localparam int HEIGHT_RESET = 4096;
    localparam int OUT_MAX      = 16383;

endpackage

// ----- hw/rtl/tile_to_atlas_coordinate_top.sv -----
// Throughput: one transaction per cycle unless m_tready is held low; the lane
// division is a restoring divider unrolled to one quotient bit per pipeline stage,
// so every stage takes a new item.
// Stalls collapse bubbles stage by stage; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and sets atlas_height to 4096.
// Depends on ttac_pkg.
module tile_to_atlas_coordinate_top
    import ttac_pkg::*;
#(
    parameter int TILE_SIZE       = TILE_SIZE_DEF,
    parameter int LANE_WIDTH      = LANE_WIDTH_DEF,
    parameter int SHORT_LANES     = SHORT_LANES_DEF,
    parameter int RESERVED_HEIGHT = RESERVED_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: atlas_height
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] tile_x, [13:3] tile_y, [15:14] zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [13:0] atlas_x, [27:14] atlas_y, [31:28] zero
);

    // Derived widths
    localparam int PY_W   = $clog2(((1 << TILE_Y_W) - 1) * TILE_SIZE + 1);
    localparam int PX_W   = $clog2(((1 << TILE_X_W) - 1) * TILE_SIZE + 1);
    localparam int DIV_W  = HEIGHT_W;
    localparam int ST_W   = DIV_W + $clog2(SHORT_LANES + 1);
    localparam int CMP_W  = (PY_W > ST_W) ? PY_W : ST_W;
    localparam int LANE_W = PY_W + 1;
    localparam int X_W    = LANE_W + $clog2(LANE_WIDTH + 1) + 1;
    localparam int Y_W    = DIV_W + 2;
    localparam int LONG_RST  = (HEIGHT_RESET <= RESERVED_HEIGHT) ?
                               (RESERVED_HEIGHT + 1) : HEIGHT_RESET;
    localparam int SHORT_RST = LONG_RST - RESERVED_HEIGHT;

    // Lane heights, refreshed on each register write
    logic [DIV_W-1:0] long_h_reg,      long_h_next;
    logic [DIV_W-1:0] short_h_reg,     short_h_next;
    logic [ST_W-1:0]  short_total_reg, short_total_next;

    assign cfg_ready = 1'b1;

    // Clamp the height above the reserved area and derive the lane heights
    always_comb
    begin
        if (cfg_data <= DIV_W'(RESERVED_HEIGHT))
        begin
            long_h_next = DIV_W'(RESERVED_HEIGHT + 1);
        end
        else
        begin
            long_h_next = cfg_data;
        end
        short_h_next     = long_h_next - DIV_W'(RESERVED_HEIGHT);
        short_total_next = ST_W'(short_h_next) * ST_W'(SHORT_LANES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_h_reg      <= DIV_W'(LONG_RST);
            short_h_reg     <= DIV_W'(SHORT_RST);
            short_total_reg <= ST_W'(SHORT_RST * SHORT_LANES);
        end
        else if (cfg_valid && cfg_ready)
        begin
            long_h_reg      <= long_h_next;
            short_h_reg     <= short_h_next;
            short_total_reg <= short_total_next;
        end
    end

    // Pipeline storage: stage 0 is the prepared item, stage k holds k quotient bits
    logic              valid_reg [0:PY_W];
    logic              long_reg  [0:PY_W];
    logic [PX_W-1:0]   px_reg    [0:PY_W];
    logic [PY_W-1:0]   dvd_reg   [0:PY_W];
    logic [PY_W-1:0]   quo_reg   [0:PY_W];
    logic [DIV_W-1:0]  rem_reg   [0:PY_W];
    logic              en        [0:PY_W];

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_x_reg, out_x_next;
    logic [OUT_W-1:0]  out_y_reg, out_y_next;
    logic              en_out;

    // Per-stage advance: a stage loads when it is empty or its content moves on
    always_comb
    begin
        en_out   = !out_valid_reg || m_tready;
        en[PY_W] = !valid_reg[PY_W] || en_out;
        for (int k = PY_W - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
    end

    assign s_tready = en[0];

    // Stage 0: scale to pixels and pick short or full-height lanes
    logic [TILE_X_W-1:0] tile_x;
    logic [TILE_Y_W-1:0] tile_y;
    logic [PY_W-1:0]     py;
    logic [PX_W-1:0]     px_next;
    logic                long_next;
    logic [PY_W-1:0]     dvd_next;

    assign tile_x = s_tdata[TILE_X_W-1:0];
    assign tile_y = s_tdata[TILE_X_W+TILE_Y_W-1:TILE_X_W];

    always_comb
    begin
        py        = PY_W'(tile_y) * PY_W'(TILE_SIZE);
        px_next   = PX_W'(tile_x) * PX_W'(TILE_SIZE);
        long_next = CMP_W'(py) >= CMP_W'(short_total_reg);
        if (long_next)
        begin
            dvd_next = PY_W'(CMP_W'(py) - CMP_W'(short_total_reg));
        end
        else
        begin
            dvd_next = py;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            valid_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            long_reg[0] <= long_next;
            px_reg[0]   <= px_next;
            dvd_reg[0]  <= dvd_next;
            quo_reg[0]  <= '0;
            rem_reg[0]  <= '0;
        end
    end

    // Division stages: one restoring step per stage, dividend MSB first
    for (genvar k = 1; k <= PY_W; k++)
    begin : g_div
        logic [DIV_W-1:0] dsr;
        logic [DIV_W:0]   trial;
        logic             qbit;
        logic [DIV_W-1:0] rem_next;

        always_comb
        begin
            dsr      = long_reg[k-1] ? long_h_reg : short_h_reg;
            trial    = {rem_reg[k-1], dvd_reg[k-1][PY_W-k]};
            qbit     = trial >= {1'b0, dsr};
            rem_next = qbit ? DIV_W'(trial - {1'b0, dsr}) : trial[DIV_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                long_reg[k] <= long_reg[k-1];
                px_reg[k]   <= px_reg[k-1];
                dvd_reg[k]  <= dvd_reg[k-1];
                quo_reg[k]  <= {quo_reg[k-1][PY_W-2:0], qbit};
                rem_reg[k]  <= rem_next;
            end
        end
    end

    // Output stage: place the lane, add the column offset, saturate
    logic [X_W-1:0] x_full;
    logic [Y_W-1:0] y_full;

    always_comb
    begin
        x_full = X_W'(X_W'(quo_reg[PY_W]) +
                      X_W'(long_reg[PY_W] ? SHORT_LANES : 0)) * X_W'(LANE_WIDTH)
                 + X_W'(px_reg[PY_W]);
        y_full = Y_W'(rem_reg[PY_W]) + Y_W'(long_reg[PY_W] ? 0 : RESERVED_HEIGHT);
        out_x_next = (x_full > X_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : x_full[OUT_W-1:0];
        out_y_next = (y_full > Y_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : y_full[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= valid_reg[PY_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_y_reg, out_x_reg};

`ifndef ASSERT_OFF
    // Final remainder lies below the divisor that was chosen for the item
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[PY_W] |->
            (rem_reg[PY_W] < (long_reg[PY_W] ? long_h_reg : short_h_reg)))
        else $error("division remainder not below lane height");

    // An empty output register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // A finished item moved into the output register shows as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (en_out && valid_reg[PY_W]) |=> m_tvalid)
        else $error("result lost at output register");
`endif

endmodule
